// ===== hdl/b512h_pkg.sv =====
// Shared types and constants of the BLAKE-512 hashing block.
// No dependencies; b512h_buf, b512h_vec, blake512_hash and tb_top import this package.
package b512h_pkg;

   typedef logic [63:0] word_type;

   // Kind of block that is being compressed.
   typedef enum logic [1:0] {
      MODE_FULL,
      MODE_PAD1,
      MODE_PAD2
   } blk_mode_type;

   // Padding context handed to the block buffer.
   typedef struct packed {
      blk_mode_type mode;
      logic [6:0]   len;
      word_type     fin_lo;
      word_type     fin_hi;
   } pad_ctl_type;

   // Control of the work vector datapath.
   typedef struct packed {
      logic shift_in;
      logic mix;
      logic half;
      logic diag;
      logic rot16;
   } vec_ctl_type;

   // Word positions of the padding tail and the last length that fits one block.
   localparam logic [3:0] TAIL_ONE_IDX = 4'd13;
   localparam logic [3:0] CNT_HI_IDX   = 4'd14;
   localparam logic [3:0] CNT_LO_IDX   = 4'd15;
   localparam logic [6:0] PAD_LIMIT    = 7'd111;

   localparam word_type IV_C [8] = '{
      64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
      64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
      64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
      64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
   };

   localparam word_type PI_C [16] = '{
      64'h243F6A8885A308D3, 64'h13198A2E03707344,
      64'hA4093822299F31D0, 64'h082EFA98EC4E6C89,
      64'h452821E638D01377, 64'hBE5466CF34E90C6C,
      64'hC0AC29B7C97C50DD, 64'h3F84D5B5B5470917,
      64'h9216D5D98979FB1B, 64'hD1310BA698DFB5AC,
      64'h2FFD72DBD01ADFB7, 64'hB8E1AFED6A267E96,
      64'hBA7C9045F12C7F99, 64'h24A19947B3916CF7,
      64'h0801F2E2858EFC16, 64'h636920D871574E69
   };

   // Message permutations, row = round mod 10, one nibble per entry, first entry in the top nibble.
   localparam logic [63:0] PERM_C [10] = '{
      64'h0123456789ABCDEF, 64'hEA489FD61C02B753,
      64'hB8C052FDAE367194, 64'h7931DCBE265A40F8,
      64'h905724AFE1BC683D, 64'h2C6A0B834D75FE19,
      64'hC51FED4A0763928B, 64'hDB7EC13950F4862A,
      64'h6FE9B308C2D714A5, 64'hA2847615FB9E3CD0
   };

   // Entry pos of permutation row.
   function automatic logic [3:0] perm_f(input logic [3:0] row, input logic [3:0] pos);
      logic [63:0] row_w;
      logic [5:0]  sh;
      row_w = PERM_C[row];
      sh    = {4'd15 - pos, 2'b00};
      row_w = row_w >> sh;
      return row_w[3:0];
   endfunction

endpackage

// ===== hdl/b512h_if.sv =====
// Handshake channels of the BLAKE-512 hashing block: message, digest and register write.
// No dependencies.
interface b512h_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, message_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface b512h_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        final_word;
   modport source (output valid, digest_word, word_index, final_word, input ready);
   modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

interface b512h_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/b512h_buf.sv =====
// Block buffer memory of the BLAKE-512 block, with padding applied on the read side.
// Depends on b512h_pkg.
module b512h_buf import b512h_pkg::*; (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  word_type    wr_data,
   input  logic [3:0]  rd_addr,
   input  pad_ctl_type pad,
   output word_type    msg_word
);

   word_type   mem [16];
   word_type   rd_ff;
   logic [3:0] ridx_ff;

   logic [3:0] q;
   logic [2:0] r;
   word_type   marker;
   word_type   w;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff   <= mem[rd_addr];
      ridx_ff <= rd_addr;
   end

   // Padding: marker byte after the data, zeros beyond, then the tail words.
   always_comb begin
      q      = pad.len[6:3];
      r      = pad.len[2:0];
      marker = 64'h8000_0000_0000_0000 >> {r, 3'b000};
      w      = rd_ff;
      unique case (pad.mode)
         MODE_PAD1: begin
            if (ridx_ff < q) begin
               w = rd_ff;
            end else if (ridx_ff == q) begin
               w = ((r == 3'd0) ? '0 : rd_ff) | marker;
            end else begin
               w = '0;
            end
            if (pad.len <= PAD_LIMIT) begin
               if (ridx_ff == TAIL_ONE_IDX) w = w | 64'd1;
               if (ridx_ff == CNT_HI_IDX)   w = pad.fin_hi;
               if (ridx_ff == CNT_LO_IDX)   w = pad.fin_lo;
            end
         end
         MODE_PAD2: begin
            w = '0;
            if (ridx_ff == TAIL_ONE_IDX) w = 64'd1;
            if (ridx_ff == CNT_HI_IDX)   w = pad.fin_hi;
            if (ridx_ff == CNT_LO_IDX)   w = pad.fin_lo;
         end
         default: w = rd_ff;
      endcase
   end

   assign msg_word = w;

endmodule

// ===== hdl/b512h_vec.sv =====
// Work vector of the BLAKE-512 block and its half-G mixing datapath.
// Depends on b512h_pkg.
module b512h_vec import b512h_pkg::*; (
   input  logic        clock,
   input  vec_ctl_type ctl,
   input  word_type    load_word,
   input  word_type    msg_word,
   output word_type    tap_lo,
   output word_type    tap_hi
);

   word_type v_ff [16];
   word_type v_in [16];
   word_type mixed [16];
   word_type a, b, c, d, t, u;
   word_type a_n, b_n, c_n, d_n;

   // Half of G on the taps; in row i the diagonal tap sits i places further along the row.
   always_comb begin
      a   = v_ff[0];
      b   = ctl.diag ? v_ff[5]  : v_ff[4];
      c   = ctl.diag ? v_ff[10] : v_ff[8];
      d   = ctl.diag ? v_ff[15] : v_ff[12];
      a_n = a + b + msg_word;
      t   = d ^ a_n;
      d_n = ctl.half ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
      c_n = c + d_n;
      u   = b ^ c_n;
      b_n = ctl.half ? {u[10:0], u[63:11]} : {u[24:0], u[63:25]};
   end

   // Next vector: mix (with a row rotation after the second half), or a shift through the whole vector.
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         mixed[k] = v_ff[k];
      end
      mixed[0] = a_n;
      if (ctl.diag) begin
         mixed[5]  = b_n;
         mixed[10] = c_n;
         mixed[15] = d_n;
      end else begin
         mixed[4]  = b_n;
         mixed[8]  = c_n;
         mixed[12] = d_n;
      end
      for (int k = 0; k < 16; k++) begin
         v_in[k] = v_ff[k];
      end
      if (ctl.shift_in || ctl.rot16) begin
         for (int k = 0; k < 15; k++) begin
            v_in[k] = v_ff[k + 1];
         end
         v_in[15] = ctl.shift_in ? load_word : v_ff[0];
      end else if (ctl.mix) begin
         if (ctl.half) begin
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 4; j++) begin
                  v_in[4 * i + j] = mixed[4 * i + ((j + 1) % 4)];
               end
            end
         end else begin
            for (int k = 0; k < 16; k++) begin
               v_in[k] = mixed[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) begin
         v_ff[k] <= v_in[k];
      end
   end

   assign tap_lo = v_ff[0];
   assign tap_hi = v_ff[8];

endmodule

// ===== hdl/blake512_hash.sv =====
// BLAKE-512 hashing block. A message word that does not complete a 128-byte block is taken
// in the idle state. A word that completes a block starts a compression: the work vector is
// loaded from the chaining memory, the 16 rounds run at one half-G step a cycle (one block
// buffer read each), and the result is folded back into the chaining memory. The last word
// adds a padding length step, one or two padding compressions, and then eight digest words,
// each offered until taken. No clearing pass is needed after reset.
// Depends on b512h_pkg, b512h_if, b512h_buf and b512h_vec.
module blake512_hash import b512h_pkg::*; (
   input logic        clock,
   input logic        reset,
   b512h_req_if.sink  req_if,
   b512h_rsp_if.source rsp_if,
   b512h_csr_if.sink  csr_if
);

   localparam logic [8:0] INIT_LAST  = 9'd16;
   localparam logic [8:0] ROUND_LAST = 9'd256;
   localparam logic [8:0] FINAL_LAST = 9'd8;
   localparam logic [8:0] DIG_LAST   = 9'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_ROUND, ST_FINAL, ST_PADCALC, ST_DIG_RD, ST_DIG_LD, ST_DIG_WAIT
   } state_type;

   state_type    state_ff;
   logic [8:0]   cnt_ff;
   logic [6:0]   buf_ff;
   word_type     ctr_lo_ff, ctr_hi_ff, fin_lo_ff, fin_hi_ff;
   logic         last_ff, nocnt_ff;
   blk_mode_type mode_ff;
   word_type     salt_ff [4];
   logic [7:0]   cvld_ff;
   logic         mix_ff, half_ff, diag_ff;
   logic [3:0]   cidx_ff;
   word_type     rsp_word_ff;
   logic [2:0]   rsp_idx_ff;
   logic         rsp_valid_ff;

   word_type     chain_mem [8];
   word_type     chain_rd_ff;
   logic [2:0]   chain_ridx_ff;
   word_type     chain_seed, chain_val;

   logic         acc;
   logic [3:0]   vb;
   word_type     masked;
   logic [7:0]   sum;
   logic         fresh;
   logic [3:0]   rnd, row, midx, cidx, k;
   word_type     fin_lo_sum;
   word_type     load_word, tap_lo, tap_hi, buf_word;
   word_type     cw_data;
   logic [2:0]   cw_addr, fin_idx;
   logic         cw_en;
   pad_ctl_type  pad;
   vec_ctl_type  vctl;

   // Input word: byte mask and new fill.
   always_comb begin
      acc = req_if.valid && (state_ff == ST_IDLE);
      if (!req_if.last_word || req_if.valid_bytes > 4'd8) begin
         vb = 4'd8;
      end else begin
         vb = req_if.valid_bytes;
      end
      masked = req_if.message_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> {vb, 3'b000});
      sum    = {1'b0, buf_ff} + {4'b0000, vb};
      fresh  = (buf_ff == '0) && (ctr_lo_ff == '0) && (ctr_hi_ff == '0);
      fin_lo_sum = ctr_lo_ff + {54'd0, buf_ff, 3'b000};
   end

   // Round schedule: permutation row and message and constant indexes of this step.
   always_comb begin
      rnd  = cnt_ff[7:4];
      row  = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
      midx = perm_f(row, {cnt_ff[3:1], cnt_ff[0]});
      cidx = perm_f(row, {cnt_ff[3:1], ~cnt_ff[0]});
   end

   // Chaining memory: one read per cycle, words never written read as the salted IV.
   always_comb begin
      chain_seed = IV_C[chain_ridx_ff] ^ (chain_ridx_ff[2] ? '0 : salt_ff[chain_ridx_ff[1:0]]);
      chain_val  = cvld_ff[chain_ridx_ff] ? chain_rd_ff : chain_seed;
      fin_idx    = cnt_ff[2:0] - 3'd1;
      cw_en      = 1'b0;
      cw_addr    = fin_idx;
      cw_data    = chain_val ^ salt_ff[fin_idx[1:0]] ^ tap_lo ^ tap_hi;
      if (state_ff == ST_FINAL && cnt_ff != '0) begin
         cw_en = 1'b1;
      end else if (csr_if.valid && !fresh && !cvld_ff[csr_if.index]) begin
         cw_en   = 1'b1;
         cw_addr = {1'b0, csr_if.index};
         cw_data = IV_C[csr_if.index] ^ salt_ff[csr_if.index];
      end
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         chain_mem[cw_addr] <= cw_data;
      end
      chain_rd_ff   <= chain_mem[cnt_ff[2:0]];
      chain_ridx_ff <= cnt_ff[2:0];
   end

   // Work vector loading: chaining words, salted constants, then constants with the counter unless nocnt.
   always_comb begin
      k = cnt_ff[3:0] - 4'd1;
      if (!k[3]) begin
         load_word = chain_val;
      end else if (!k[2]) begin
         load_word = salt_ff[k[1:0]] ^ PI_C[k[1:0]];
      end else if (nocnt_ff) begin
         load_word = PI_C[{2'b01, k[1:0]}];
      end else if (mode_ff == MODE_FULL) begin
         load_word = PI_C[{2'b01, k[1:0]}] ^ (k[1] ? ctr_hi_ff : ctr_lo_ff);
      end else begin
         load_word = PI_C[{2'b01, k[1:0]}] ^ (k[1] ? fin_hi_ff : fin_lo_ff);
      end
      vctl.shift_in = (state_ff == ST_INIT) && (cnt_ff != '0);
      vctl.mix      = mix_ff;
      vctl.half     = half_ff;
      vctl.diag     = diag_ff;
      vctl.rot16    = (state_ff == ST_FINAL) && (cnt_ff != '0);
      pad.mode      = mode_ff;
      pad.len       = buf_ff;
      pad.fin_lo    = fin_lo_ff;
      pad.fin_hi    = fin_hi_ff;
   end

   b512h_buf u_buf (
      .clock    (clock),
      .wr_en    (acc),
      .wr_addr  (buf_ff[6:3]),
      .wr_data  (masked),
      .rd_addr  (midx),
      .pad      (pad),
      .msg_word (buf_word)
   );

   b512h_vec u_vec (
      .clock     (clock),
      .ctl       (vctl),
      .load_word (load_word),
      .msg_word  (buf_word ^ PI_C[cidx_ff]),
      .tap_lo    (tap_lo),
      .tap_hi    (tap_hi)
   );

   // Sequencer: word intake, compressions, padding and digest output.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         buf_ff       <= '0;
         ctr_lo_ff    <= '0;
         ctr_hi_ff    <= '0;
         last_ff      <= 1'b0;
         nocnt_ff     <= 1'b0;
         mode_ff      <= MODE_FULL;
         cvld_ff      <= '0;
         mix_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            salt_ff[i] <= '0;
         end
      end else begin
         mix_ff  <= (state_ff == ST_ROUND) && (cnt_ff != ROUND_LAST);
         half_ff <= cnt_ff[0];
         diag_ff <= cnt_ff[3];
         cidx_ff <= cidx;
         unique case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  last_ff <= req_if.last_word;
                  cnt_ff  <= '0;
                  if (sum[7]) begin
                     buf_ff    <= '0;
                     ctr_lo_ff <= ctr_lo_ff + 64'd1024;
                     ctr_hi_ff <= ctr_hi_ff + {63'd0, &ctr_lo_ff[63:10]};
                     mode_ff   <= MODE_FULL;
                     nocnt_ff  <= 1'b0;
                     state_ff  <= ST_INIT;
                  end else begin
                     buf_ff <= sum[6:0];
                     if (req_if.last_word) state_ff <= ST_PADCALC;
                  end
               end
            end
            ST_PADCALC: begin
               fin_lo_ff <= fin_lo_sum;
               fin_hi_ff <= ctr_hi_ff + {63'd0, fin_lo_sum < ctr_lo_ff};
               mode_ff   <= MODE_PAD1;
               nocnt_ff  <= (buf_ff == '0);
               cnt_ff    <= '0;
               state_ff  <= ST_INIT;
            end
            ST_INIT: begin
               if (cnt_ff == INIT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 9'd1;
               end
            end
            ST_ROUND: begin
               if (cnt_ff == ROUND_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_FINAL;
               end else begin
                  cnt_ff <= cnt_ff + 9'd1;
               end
            end
            ST_FINAL: begin
               if (cnt_ff != '0) cvld_ff[fin_idx] <= 1'b1;
               if (cnt_ff == FINAL_LAST) begin
                  cnt_ff <= '0;
                  unique case (mode_ff)
                     MODE_FULL: state_ff <= last_ff ? ST_PADCALC : ST_IDLE;
                     MODE_PAD1: begin
                        if (buf_ff > PAD_LIMIT) begin
                           mode_ff  <= MODE_PAD2;
                           nocnt_ff <= 1'b1;
                           state_ff <= ST_INIT;
                        end else begin
                           state_ff <= ST_DIG_RD;
                        end
                     end
                     default: state_ff <= ST_DIG_RD;
                  endcase
               end else begin
                  cnt_ff <= cnt_ff + 9'd1;
               end
            end
            ST_DIG_RD: state_ff <= ST_DIG_LD;
            ST_DIG_LD: begin
               rsp_word_ff  <= chain_val;
               rsp_idx_ff   <= chain_ridx_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_DIG_WAIT;
            end
            ST_DIG_WAIT: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (cnt_ff == DIG_LAST) begin
                     cnt_ff    <= '0;
                     buf_ff    <= '0;
                     ctr_lo_ff <= '0;
                     ctr_hi_ff <= '0;
                     cvld_ff   <= '0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + 9'd1;
                     state_ff <= ST_DIG_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // Salt writes; before the first word a write reseeds, later the old seed is kept.
         if (csr_if.valid) begin
            salt_ff[csr_if.index] <= csr_if.data;
            if (fresh) begin
               cvld_ff[csr_if.index] <= 1'b0;
            end else begin
               cvld_ff[csr_if.index] <= 1'b1;
            end
         end
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digest_word = rsp_word_ff;
   assign rsp_if.word_index  = rsp_idx_ff;
   assign rsp_if.final_word  = (rsp_idx_ff == DIG_LAST[2:0]);

`ifndef SYNTHESIS
   // No word is taken while a digest word is offered.
   a_no_intake_during_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready) else $error("word taken during digest output");

   // A last word always starts the closing sequence.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.last_word) |=> !req_if.ready)
      else $error("last word did not start padding");

   // A final mark is only seen on the eighth digest word.
   a_final_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.final_word) |-> (rsp_if.word_index == 3'd7))
      else $error("final mark on wrong digest word");

   // Rounds only run on a loaded vector.
   a_round_after_init: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_ROUND) |-> $past(state_ff == ST_INIT))
      else $error("rounds started without vector load");
`endif

endmodule

// ===== tb/tb_b512h_if.sv =====
// Testbench-side records of the BLAKE-512 testbench: message words and digest words.
// No dependencies; the testbench connects through the RTL interfaces in hdl/b512h_if.sv.
package tb_b512h_types;

   // One message word as offered on the request channel.
   typedef struct {
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        last;
   } msg_word_type;

   // One digest word as expected on the result channel.
   typedef struct {
      logic [63:0] digest;
      logic [2:0]  idx;
      logic        fin;
   } digest_rec_type;

endpackage

// ===== tb/tb_top.sv =====
// Self-checking testbench of the BLAKE-512 hashing block: directed and random messages,
// salt changes, random stalls on both channels, all checked against a built-in predictor.
// Depends on b512h_pkg, b512h_if, tb_b512h_types and blake512_hash.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import b512h_pkg::*;
   import tb_b512h_types::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int CSR_SALT0   = 0;
   localparam int N_RANDOM    = 500;

   logic clock;
   logic reset;

   b512h_req_if req_if ();
   b512h_rsp_if rsp_if ();
   b512h_csr_if csr_if ();

   blake512_hash u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   // Predictor state: salt, chaining value, block buffer, counters.
   logic [63:0] p_salt [4];
   logic [63:0] p_chain [8];
   logic [63:0] p_buf [16];
   logic [63:0] p_vec [16];
   int unsigned p_fill;
   logic [127:0] p_count;

   digest_rec_type digest_q [$];
   int   n_errors;
   int   n_words_sent;
   int   n_digests;
   int   n_msgs;
   int   cycles;
   bit   hold_off;

   // Message permutation entry, taken from the published schedule.
   function automatic logic [3:0] sched(int r, int k);
      logic [63:0] rows [10];
      rows = '{64'h0123456789ABCDEF, 64'hEA489FD61C02B753, 64'hB8C052FDAE367194,
               64'h7931DCBE265A40F8, 64'h905724AFE1BC683D, 64'h2C6A0B834D75FE19,
               64'hC51FED4A0763928B, 64'hDB7EC13950F4862A, 64'h6FE9B308C2D714A5,
               64'hA2847615FB9E3CD0};
      return rows[r][63 - 4 * k -: 4];
   endfunction

   function automatic logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic g_step(int a, int b, int c, int d, int x, int y);
      p_vec[a] = p_vec[a] + p_vec[b] + (p_buf[x] ^ PI_C[y]);
      p_vec[d] = rotr(p_vec[d] ^ p_vec[a], 32);
      p_vec[c] = p_vec[c] + p_vec[d];
      p_vec[b] = rotr(p_vec[b] ^ p_vec[c], 25);
      p_vec[a] = p_vec[a] + p_vec[b] + (p_buf[y] ^ PI_C[x]);
      p_vec[d] = rotr(p_vec[d] ^ p_vec[a], 16);
      p_vec[c] = p_vec[c] + p_vec[d];
      p_vec[b] = rotr(p_vec[b] ^ p_vec[c], 11);
   endtask

   // One compression of the block buffer into the chaining value.
   task automatic compress_block(logic [127:0] ctr, bit no_count);
      int r;
      for (int i = 0; i < 8; i++) p_vec[i] = p_chain[i];
      for (int i = 0; i < 4; i++) p_vec[8 + i] = p_salt[i] ^ PI_C[i];
      for (int i = 0; i < 4; i++) p_vec[12 + i] = PI_C[4 + i];
      if (!no_count) begin
         p_vec[12] ^= ctr[63:0];
         p_vec[13] ^= ctr[63:0];
         p_vec[14] ^= ctr[127:64];
         p_vec[15] ^= ctr[127:64];
      end
      for (r = 0; r < 16; r++) begin
         g_step(0, 4, 8, 12, sched(r % 10, 0), sched(r % 10, 1));
         g_step(1, 5, 9, 13, sched(r % 10, 2), sched(r % 10, 3));
         g_step(2, 6, 10, 14, sched(r % 10, 4), sched(r % 10, 5));
         g_step(3, 7, 11, 15, sched(r % 10, 6), sched(r % 10, 7));
         g_step(0, 5, 10, 15, sched(r % 10, 8), sched(r % 10, 9));
         g_step(1, 6, 11, 12, sched(r % 10, 10), sched(r % 10, 11));
         g_step(2, 7, 8, 13, sched(r % 10, 12), sched(r % 10, 13));
         g_step(3, 4, 9, 14, sched(r % 10, 14), sched(r % 10, 15));
      end
      for (int i = 0; i < 8; i++)
         p_chain[i] ^= p_salt[i & 3] ^ p_vec[i] ^ p_vec[i + 8];
   endtask

   task automatic start_message();
      for (int i = 0; i < 8; i++) p_chain[i] = IV_C[i] ^ (i < 4 ? p_salt[i] : 64'd0);
      for (int i = 0; i < 16; i++) p_buf[i] = '0;
      p_fill  = 0;
      p_count = '0;
   endtask

   task automatic set_byte(int unsigned pos, logic [7:0] v);
      p_buf[(pos >> 3) & 15][63 - 8 * (pos & 7) -: 8] = v;
   endtask

   // Salt write as the predictor sees it; reseeds the chain only between messages.
   task automatic salt_written(int idx, logic [63:0] v);
      p_salt[idx] = v;
      if (p_fill == 0 && p_count == 0) p_chain[idx] = IV_C[idx] ^ v;
   endtask

   // Absorb one accepted message word; a last word queues the eight digest words.
   task automatic absorb_word(msg_word_type w);
      int unsigned nb;
      logic [63:0] d;
      logic [127:0] fin;
      int unsigned len;
      digest_rec_type rec;
      nb = w.last ? ((w.nbytes > 8) ? 8 : w.nbytes) : 8;
      d  = w.data;
      if (nb < 8) d = (nb == 0) ? 64'd0 : d & (~64'd0 << (64 - 8 * nb));
      p_buf[(p_fill >> 3) & 15] = d;
      p_fill += nb;
      if (p_fill >= 128) begin
         p_count += 128'd1024;
         compress_block(p_count, 1'b0);
         p_fill = 0;
      end
      if (!w.last) return;
      len = p_fill;
      fin = p_count + 128'(len * 8);
      for (int unsigned p = len; p < 128; p++) set_byte(p, 8'h00);
      set_byte(len, 8'h80);
      if (len <= 111) begin
         p_buf[13] |= 64'h1;
         p_buf[14] = fin[127:64];
         p_buf[15] = fin[63:0];
         compress_block(fin, len == 0);
      end else begin
         compress_block(fin, 1'b0);
         for (int i = 0; i < 16; i++) p_buf[i] = '0;
         p_buf[13] = 64'h1;
         p_buf[14] = fin[127:64];
         p_buf[15] = fin[63:0];
         compress_block('0, 1'b1);
      end
      for (int i = 0; i < 8; i++) begin
         rec.digest = p_chain[i];
         rec.idx    = 3'(i);
         rec.fin    = (i == 7);
         digest_q.push_back(rec);
      end
      n_msgs++;
      start_message();
   endtask

   // Clock and cycle limit.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top failed");
         $finish;
      end
   end

   // Short gaps mostly, occasionally a long one.
   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Send one word at a falling edge and wait for its acceptance, then update the
   // predictor. Valid stays high after acceptance until the next word or a release.
   task automatic send_word(msg_word_type w);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g != 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.message_word <= w.data;
      req_if.valid_bytes  <= w.nbytes;
      req_if.last_word    <= w.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      absorb_word(w);
      n_words_sent++;
   endtask

   // Drop the request valid at the next falling edge.
   task automatic release_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Register write while the block is idle.
   task automatic write_salt(int idx, logic [63:0] v);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= 2'(CSR_SALT0 + idx);
      csr_if.data  <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      salt_written(idx, v);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      release_req();
      while (digest_q.size() != 0) @(posedge clock);
      while (guard < 400) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Random message: lengths mostly short, a few spanning blocks, random last count.
   task automatic send_message(int n_words);
      msg_word_type w;
      for (int i = 0; i < n_words; i++) begin
         w.data   = {$urandom, $urandom};
         w.nbytes = 4'($urandom_range(0, 15));
         w.last   = (i == n_words - 1);
         send_word(w);
      end
      release_req();
   endtask

   // Result checker: every accepted digest word against the oldest expectation.
   always @(posedge clock) begin
      digest_rec_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_digests++;
         if (digest_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("unexpected digest word %h index %0d", rsp_if.digest_word,
                        rsp_if.word_index);
         end else begin
            e = digest_q.pop_front();
            if (rsp_if.digest_word !== e.digest || rsp_if.word_index !== e.idx ||
                rsp_if.final_word !== e.fin) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           e.digest, e.idx, e.fin, rsp_if.digest_word,
                           rsp_if.word_index, rsp_if.final_word);
            end
         end
      end
   end

   // Receiver stalls; a long hold-off is requested by the stimulus.
   initial begin
      int g;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   // Directed table: extremes of the fields as one-word messages.
   msg_word_type dir_tab [$];

   initial begin
      int nw;
      n_errors = 0; n_words_sent = 0; n_digests = 0; n_msgs = 0; cycles = 0;
      hold_off = 0;
      for (int i = 0; i < 4; i++) p_salt[i] = '0;
      start_message();
      req_if.valid = 1'b0;
      req_if.message_word = '0;
      req_if.valid_bytes = '0;
      req_if.last_word = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty message, all-ones bytes, oversized counts and a single byte.
      dir_tab.push_back('{64'h0, 4'd0, 1'b1});
      dir_tab.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1});
      dir_tab.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1});
      dir_tab.push_back('{64'h0123_4567_89AB_CDEF, 4'd1, 1'b1});
      dir_tab.push_back('{64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b1});
      foreach (dir_tab[i]) send_word(dir_tab[i]);
      // Byte 111 merged pad: 13 full words then 7 bytes.
      for (int i = 0; i < 14; i++)
         send_word('{{$urandom, $urandom}, (i == 13) ? 4'd7 : 4'd3, i == 13 ? 1'b1 : 1'b0});
      drain();
      // Two-block padding with 14 words then 1 byte; then 16 full words and an empty last word.
      for (int i = 0; i < 15; i++) send_word('{{$urandom, $urandom}, 4'd1, i == 14});
      for (int i = 0; i < 17; i++) send_word('{{$urandom, $urandom}, 4'd0, i == 16});
      drain();

      // Salt extremes, including a mid-message write.
      write_salt(0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_salt(1, 64'h0);
      write_salt(2, 64'h8000_0000_0000_0001);
      write_salt(3, 64'hFFFF_FFFF_FFFF_FFFF);
      send_message(3);
      send_word('{64'hDEAD_BEEF_0000_0001, 4'd8, 1'b0});
      drain();
      write_salt(1, {$urandom, $urandom});
      send_word('{64'h5555_AAAA_5555_AAAA, 4'd6, 1'b1});
      drain();

      // Long receiver hold-off while several messages are offered.
      hold_off = 1;
      fork
         begin
            repeat (800) @(posedge clock);
            hold_off = 0;
         end
         for (int m = 0; m < 4; m++) send_message(1);
      join

      // Random messages with occasional salt changes between them.
      while (n_words_sent < N_RANDOM) begin
         nw = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
         send_message(nw);
         if ($urandom_range(0, 7) == 0) begin
            drain();
            write_salt($urandom_range(0, 3), {$urandom, $urandom});
         end
      end
      drain();

      $display("sent %0d message words in %0d messages; checked %0d digest words",
               n_words_sent, n_msgs, n_digests);
      if (n_errors == 0 && digest_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d digest words outstanding", n_errors, digest_q.size());
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
